// ===== hw/rtl/tunnel_url_parser_top_assert.svh =====
// Assertion macros for the tunnel URL parser checker.
// Every assertion is clocked on aclk and held off while aresetn is low.
`ifndef TUNNEL_URL_PARSER_TOP_ASSERT_SVH
`define TUNNEL_URL_PARSER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TUP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TUP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tup_pkg.sv =====
package tup_pkg;

    // Field limits
    localparam int TRANSPORT_NAME_MAX = 16;
    localparam int SERVER_LEN_MAX     = 255;
    localparam int PORT_DIGITS_MAX    = 20;
    localparam int ENCODING_NAME_MAX  = 16;
    localparam int OPTIONS_LEN_MAX    = 255;
    localparam int ENCODINGS_MAX      = 8;

    localparam int FIELD_MAX_A = (TRANSPORT_NAME_MAX > SERVER_LEN_MAX) ?
                                 TRANSPORT_NAME_MAX : SERVER_LEN_MAX;
    localparam int FIELD_MAX_B = (PORT_DIGITS_MAX > ENCODING_NAME_MAX) ?
                                 PORT_DIGITS_MAX : ENCODING_NAME_MAX;
    localparam int FIELD_MAX_C = (FIELD_MAX_A > FIELD_MAX_B) ? FIELD_MAX_A : FIELD_MAX_B;
    localparam int FIELD_MAX   = (FIELD_MAX_C > OPTIONS_LEN_MAX) ? FIELD_MAX_C : OPTIONS_LEN_MAX;
    localparam int FL_W        = $clog2(FIELD_MAX + 1);

    localparam int ACC_W = 17;
    localparam logic [ACC_W-1:0] PORT_SAT   = 17'd65536;
    localparam logic [ACC_W-1:0] PORT_MAX8  = 17'd255;
    localparam logic [ACC_W-1:0] PORT_MAX16 = 17'd65535;
    localparam logic [8:0]       OPT_SAT    = 9'd511;
    localparam logic [3:0]       IDX_SAT    = 4'd15;

    // Result kinds
    localparam logic [1:0] KIND_SERVER    = 2'd0;
    localparam logic [1:0] KIND_ENC_BEGIN = 2'd1;
    localparam logic [1:0] KIND_OPTION    = 2'd2;
    localparam logic [1:0] KIND_FIN       = 2'd3;

    // Status codes
    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_NO_SCHEME_SEP = 4'd1;
    localparam logic [3:0] ST_BAD_TRANSPORT = 4'd2;
    localparam logic [3:0] ST_NO_COLON      = 4'd3;
    localparam logic [3:0] ST_NO_PORT       = 4'd4;
    localparam logic [3:0] ST_PORT_RANGE    = 4'd5;
    localparam logic [3:0] ST_NO_QUERY      = 4'd6;
    localparam logic [3:0] ST_NO_ENC_NAME   = 4'd7;
    localparam logic [3:0] ST_BAD_ENCODING  = 4'd8;
    localparam logic [3:0] ST_NO_PLUS       = 4'd9;
    localparam logic [3:0] ST_TOO_MANY      = 4'd10;

    // Transport codes
    localparam logic [2:0] TR_IP = 3'd0;

    // Name tables, zero padded
    localparam int TR_NUM   = 5;
    localparam int EN_NUM   = 2;
    localparam int CH_SLOTS = 8;
    localparam int CH_AW    = $clog2(CH_SLOTS);

    localparam logic [7:0] TR_CHARS [TR_NUM][CH_SLOTS] = '{
        '{"i", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "i", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "c", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"u", "d", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"u", "d", "p", "l", "i", "t", "e", 8'h00}
    };
    localparam int TR_LEN [TR_NUM] = '{2, 4, 3, 3, 7};

    localparam logic [7:0] EN_CHARS [EN_NUM][CH_SLOTS] = '{
        '{"c", "r", "y", "p", "t", 8'h00, 8'h00, 8'h00},
        '{"p", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam int EN_LEN [EN_NUM] = '{5, 3};

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [2:0]  transport_code;
        logic [15:0] port_number;
        logic [3:0]  encoding_slot;
        logic        encoding_id;
        logic [8:0]  option_count;
        logic [3:0]  status;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [1:0] num;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return is_digit(b) || ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
    endfunction

endpackage

// ===== hw/rtl/tup_front.sv =====
module tup_front import tup_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       in_ready,
    input  logic [7:0] s_url_byte,
    output push_t      push
);

    typedef enum logic [6:0] {
        PH_TRANS   = 7'b0000001,
        PH_SEP     = 7'b0000010,
        PH_SERVER  = 7'b0000100,
        PH_PORT    = 7'b0001000,
        PH_ENCNAME = 7'b0010000,
        PH_OPTS    = 7'b0100000,
        PH_OVER    = 7'b1000000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [FL_W-1:0]     fl_reg, fl_next;
    logic [TR_NUM-1:0]   thits_reg, thits_next;
    logic [EN_NUM-1:0]   ehits_reg, ehits_next;
    logic [2:0]          chosen_reg, chosen_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [3:0]          idx_reg, idx_next;
    logic [8:0]          opt_reg, opt_next;
    logic                sep_reg, sep_next;
    logic                drop_reg, drop_next;

    logic                accept;
    logic [7:0]          b;
    logic                tr_found;
    logic [2:0]          tr_sel;
    logic                en_found;
    logic                en_sel;
    logic [20:0]         acc_mul;
    logic [ACC_W-1:0]    port_limit;

    logic                fin;
    logic [3:0]          fin_status;
    logic                clr;
    logic                close;
    logic [8:0]          cl_opt;
    logic [3:0]          idx_inc;
    logic [1:0]          num;
    rec_t                rec0, rec1, r_fin;

    assign accept = s_valid && in_ready;
    assign b      = s_url_byte;

    // Lowest-index transport and encoding that still match at the current length
    always_comb begin
        tr_found = 1'b0;
        tr_sel   = 3'd0;
        for (int i = TR_NUM - 1; i >= 0; i--) begin
            if (thits_reg[i] && (fl_reg == FL_W'(TR_LEN[i]))) begin
                tr_found = 1'b1;
                tr_sel   = 3'(i);
            end
        end
        en_found = 1'b0;
        en_sel   = 1'b0;
        for (int i = EN_NUM - 1; i >= 0; i--) begin
            if (ehits_reg[i] && (fl_reg == FL_W'(EN_LEN[i]))) begin
                en_found = 1'b1;
                en_sel   = 1'(i);
            end
        end
    end

    assign acc_mul    = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {17'd0, b[3:0]};
    assign port_limit = (chosen_reg == TR_IP) ? PORT_MAX8 : PORT_MAX16;
    assign idx_inc    = (idx_reg != IDX_SAT) ? idx_reg + 4'd1 : idx_reg;

    always_comb begin
        phase_next  = phase_reg;
        fl_next     = fl_reg;
        thits_next  = thits_reg;
        ehits_next  = ehits_reg;
        chosen_next = chosen_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        opt_next    = opt_reg;
        sep_next    = sep_reg;
        drop_next   = drop_reg;
        fin         = 1'b0;
        fin_status  = ST_OK;
        clr         = 1'b0;
        close       = 1'b0;
        cl_opt      = 9'd0;
        num         = 2'd0;
        rec0        = '0;
        rec1        = '0;
        r_fin       = '0;

        if (accept) begin
            if (drop_reg) begin
                // drop bytes up to and including the terminator
                clr = (b == 8'h00);
            end else begin
                unique case (phase_reg)
                    PH_TRANS: begin
                        if (is_alnum(b) && (fl_reg < FL_W'(TRANSPORT_NAME_MAX))) begin
                            for (int i = 0; i < TR_NUM; i++) begin
                                if ((fl_reg >= FL_W'(TR_LEN[i])) ||
                                    (TR_CHARS[i][fl_reg[CH_AW-1:0]] != b)) begin
                                    thits_next[i] = 1'b0;
                                end
                            end
                            fl_next = fl_reg + FL_W'(1);
                        end else if (b == ":") begin
                            phase_next = PH_SEP;
                            sep_next   = 1'b0;
                        end else begin
                            fin        = 1'b1;
                            fin_status = ST_NO_SCHEME_SEP;
                        end
                    end
                    PH_SEP: begin
                        if (b != "/") begin
                            fin        = 1'b1;
                            fin_status = ST_NO_SCHEME_SEP;
                        end else if (!sep_reg) begin
                            sep_next = 1'b1;
                        end else if (!tr_found) begin
                            fin        = 1'b1;
                            fin_status = ST_BAD_TRANSPORT;
                        end else begin
                            chosen_next = tr_sel;
                            phase_next  = PH_SERVER;
                            fl_next     = '0;
                        end
                    end
                    PH_SERVER: begin
                        if ((fl_reg < FL_W'(SERVER_LEN_MAX)) &&
                            (is_alnum(b) || (b == ".") || (b == "-"))) begin
                            fl_next             = fl_reg + FL_W'(1);
                            num                 = 2'd1;
                            rec0.kind           = KIND_SERVER;
                            rec0.byte_value     = b;
                            rec0.transport_code = chosen_reg;
                        end else if (b == ":") begin
                            phase_next = PH_PORT;
                            fl_next    = '0;
                            acc_next   = '0;
                        end else begin
                            fin        = 1'b1;
                            fin_status = ST_NO_COLON;
                        end
                    end
                    PH_PORT: begin
                        if ((fl_reg < FL_W'(PORT_DIGITS_MAX)) && is_digit(b)) begin
                            acc_next = (acc_mul > {4'd0, PORT_SAT}) ? PORT_SAT
                                                                    : acc_mul[ACC_W-1:0];
                            fl_next  = fl_reg + FL_W'(1);
                        end else if (fl_reg == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_NO_PORT;
                        end else if (acc_reg > port_limit) begin
                            fin        = 1'b1;
                            fin_status = ST_PORT_RANGE;
                        end else if (b == 8'h00) begin
                            fin        = 1'b1;
                            fin_status = ST_OK;
                        end else if (b == "?") begin
                            phase_next = PH_ENCNAME;
                            fl_next    = '0;
                            ehits_next = '1;
                        end else begin
                            fin        = 1'b1;
                            fin_status = ST_NO_QUERY;
                        end
                    end
                    PH_ENCNAME: begin
                        if (is_alnum(b) && (fl_reg < FL_W'(ENCODING_NAME_MAX))) begin
                            for (int i = 0; i < EN_NUM; i++) begin
                                if ((fl_reg >= FL_W'(EN_LEN[i])) ||
                                    (EN_CHARS[i][fl_reg[CH_AW-1:0]] != b)) begin
                                    ehits_next[i] = 1'b0;
                                end
                            end
                            fl_next = fl_reg + FL_W'(1);
                        end else if (fl_reg == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_NO_ENC_NAME;
                        end else if (!en_found) begin
                            fin        = 1'b1;
                            fin_status = ST_BAD_ENCODING;
                        end else begin
                            ehits_next          = en_sel ? 2'b10 : 2'b01;
                            num                 = 2'd1;
                            rec0.kind           = KIND_ENC_BEGIN;
                            rec0.transport_code = chosen_reg;
                            rec0.encoding_slot  = idx_reg;
                            rec0.encoding_id    = en_sel;
                            rec0.option_count   = opt_reg;
                            opt_next            = '0;
                            if (b == "=") begin
                                phase_next = PH_OPTS;
                                fl_next    = '0;
                            end else begin
                                close  = 1'b1;
                                cl_opt = 9'd0;
                            end
                        end
                    end
                    PH_OPTS: begin
                        if ((b != 8'h00) && (b != "+") && (fl_reg < FL_W'(OPTIONS_LEN_MAX))) begin
                            fl_next = fl_reg + FL_W'(1);
                            if ((b == ",") && (opt_reg != OPT_SAT)) begin
                                opt_next = opt_reg + 9'd1;
                            end
                            num                 = 2'd1;
                            rec0.kind           = KIND_OPTION;
                            rec0.byte_value     = (b == ",") ? 8'h00 : b;
                            rec0.transport_code = chosen_reg;
                            rec0.encoding_slot  = idx_reg;
                            rec0.encoding_id    = ehits_reg[1];
                        end else begin
                            close  = 1'b1;
                            cl_opt = (opt_reg != OPT_SAT) ? opt_reg + 9'd1 : opt_reg;
                        end
                    end
                    PH_OVER: begin
                        fin        = 1'b1;
                        fin_status = (b == 8'h00) ? ST_OK : ST_TOO_MANY;
                    end
                    default: begin
                        clr = 1'b1;
                    end
                endcase
            end
        end

        // close the current encoding: count it, then look at the separator
        if (close) begin
            idx_next = idx_inc;
            opt_next = cl_opt;
            if (b == 8'h00) begin
                fin        = 1'b1;
                fin_status = ST_OK;
            end else if (b == "+") begin
                if (idx_inc >= 4'(ENCODINGS_MAX)) begin
                    phase_next = PH_OVER;
                end else begin
                    phase_next = PH_ENCNAME;
                    fl_next    = '0;
                    ehits_next = '1;
                end
            end else begin
                fin        = 1'b1;
                fin_status = ST_NO_PLUS;
            end
        end

        if (fin) begin
            r_fin.kind           = KIND_FIN;
            r_fin.transport_code = chosen_reg;
            r_fin.port_number    = (fin_status == ST_OK) ? acc_reg[15:0] : 16'd0;
            r_fin.encoding_slot  = idx_next;
            r_fin.option_count   = opt_next;
            r_fin.status         = fin_status;
            r_fin.last           = 1'b1;
            if (num == 2'd0) begin
                rec0 = r_fin;
            end else begin
                rec1 = r_fin;
            end
            num = num + 2'd1;
        end

        if (fin || clr) begin
            phase_next  = PH_TRANS;
            fl_next     = '0;
            thits_next  = '1;
            ehits_next  = '1;
            chosen_next = '0;
            acc_next    = '0;
            idx_next    = '0;
            opt_next    = '0;
            sep_next    = 1'b0;
            drop_next   = fin && (b != 8'h00);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TRANS;
            fl_reg     <= '0;
            thits_reg  <= '1;
            ehits_reg  <= '1;
            chosen_reg <= '0;
            acc_reg    <= '0;
            idx_reg    <= '0;
            opt_reg    <= '0;
            sep_reg    <= 1'b0;
            drop_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            fl_reg     <= fl_next;
            thits_reg  <= thits_next;
            ehits_reg  <= ehits_next;
            chosen_reg <= chosen_next;
            acc_reg    <= acc_next;
            idx_reg    <= idx_next;
            opt_reg    <= opt_next;
            sep_reg    <= sep_next;
            drop_reg   <= drop_next;
        end
    end

    assign push.num  = num;
    assign push.rec0 = rec0;
    assign push.rec1 = rec1;

endmodule

// ===== hw/rtl/tup_queue.sv =====
module tup_queue import tup_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  space_ok,
    output rec_t  head,
    output logic  head_valid,
    input  logic  pop
);

    rec_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, wr_next;
    logic [Q_AW-1:0] rd_reg, rd_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    logic [Q_AW-1:0] wr_plus1;

    // take a byte only when both records it may raise fit
    assign space_ok   = (cnt_reg <= (Q_AW+1)'(Q_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];
    assign wr_plus1   = wr_reg + Q_AW'(1);

    always_comb begin
        wr_next  = wr_reg + Q_AW'(push.num);
        rd_next  = pop ? rd_reg + Q_AW'(1) : rd_reg;
        cnt_next = cnt_reg + (Q_AW+1)'(push.num) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem[wr_reg] <= push.rec0;
        end
        if (push.num == 2'd2) begin
            mem[wr_plus1] <= push.rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/tup_back.sv =====
module tup_back import tup_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  rec_t        head,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_byte_value,
    output logic [2:0]  m_transport_code,
    output logic [15:0] m_port_number,
    output logic [3:0]  m_encoding_slot,
    output logic        m_encoding_id,
    output logic [8:0]  m_option_count,
    output logic [3:0]  m_status,
    output logic        m_last
);

    logic valid_reg;
    rec_t data_reg;

    // refill whenever the output register is empty or being drained
    assign pop = head_valid && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= head;
        end
    end

    assign m_valid          = valid_reg;
    assign m_kind           = data_reg.kind;
    assign m_byte_value     = data_reg.byte_value;
    assign m_transport_code = data_reg.transport_code;
    assign m_port_number    = data_reg.port_number;
    assign m_encoding_slot  = data_reg.encoding_slot;
    assign m_encoding_id    = data_reg.encoding_id;
    assign m_option_count   = data_reg.option_count;
    assign m_status         = data_reg.status;
    assign m_last           = data_reg.last;

endmodule

// ===== hw/rtl/tunnel_url_parser_top.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_url_byte (8)
// m_        out        m_valid/m_ready    kind, byte_value, transport_code, port_number,
//                                         encoding_slot, encoding_id, option_count,
//                                         status, last
//
// One URL byte per cycle is taken while the result queue has two free entries.
// A byte raises at most two records; the output register drains one record per cycle while m_ready is high.
// A record is written into the result queue at its byte's transaction, then into the output register that drives m_.
// Reset (aresetn low, synchronous) clears parser state, queue pointers and m_valid.
// Stalls on m_ready back up through the queue to s_ready; the front keeps its state.
module tunnel_url_parser_top import tup_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_url_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_byte_value,
    output logic [2:0]  m_transport_code,
    output logic [15:0] m_port_number,
    output logic [3:0]  m_encoding_slot,
    output logic        m_encoding_id,
    output logic [8:0]  m_option_count,
    output logic [3:0]  m_status,
    output logic        m_last
);

    push_t push;      // records raised by the accepted byte
    rec_t  head;      // oldest queued record
    logic  head_valid;
    logic  pop;

    // Front: classify each byte, update running parse state, raise records
    tup_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .in_ready   (s_ready),
        .s_url_byte (s_url_byte),
        .push       (push)
    );

    // Queue: decouple the parser from the result channel
    tup_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .space_ok   (s_ready),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // Back: hold one record on m_ until its transaction completes
    tup_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head             (head),
        .head_valid       (head_valid),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_byte_value     (m_byte_value),
        .m_transport_code (m_transport_code),
        .m_port_number    (m_port_number),
        .m_encoding_slot  (m_encoding_slot),
        .m_encoding_id    (m_encoding_id),
        .m_option_count   (m_option_count),
        .m_status         (m_status),
        .m_last           (m_last)
    );

endmodule

// ===== hw/rtl/tup_checker.sv =====
`include "tunnel_url_parser_top_assert.svh"

module tup_checker import tup_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_byte_value,
    input logic [2:0]  m_transport_code,
    input logic [15:0] m_port_number,
    input logic [3:0]  m_encoding_slot,
    input logic        m_encoding_id,
    input logic [8:0]  m_option_count,
    input logic [3:0]  m_status,
    input logic        m_last
);

    logic [47:0] m_fields;

    assign m_fields = {m_kind, m_byte_value, m_transport_code, m_port_number,
                       m_encoding_slot, m_encoding_id, m_option_count, m_status, m_last};

    `TUP_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_fields), "result dropped or changed while stalled")
    `TUP_ASSERT_NOW(a_last_fin, m_valid, m_last == (m_kind == KIND_FIN), "last flag does not match finished kind")
    `TUP_ASSERT_NOW(a_mid_clean, m_valid && (m_kind != KIND_FIN), (m_status == ST_OK) && (m_port_number == 16'd0), "status or port on a non-finished record")
    `TUP_ASSERT_NOW(a_err_port, m_valid && (m_kind == KIND_FIN) && (m_status != ST_OK), m_port_number == 16'd0, "port shown on a failed URL")
    `TUP_ASSERT_NOW(a_server_clean, m_valid && (m_kind == KIND_SERVER), (m_encoding_slot == 4'd0) && (m_option_count == 9'd0) && !m_encoding_id, "encoding fields set on a server byte")

endmodule

bind tunnel_url_parser_top tup_checker u_tup_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_kind           (m_kind),
    .m_byte_value     (m_byte_value),
    .m_transport_code (m_transport_code),
    .m_port_number    (m_port_number),
    .m_encoding_slot  (m_encoding_slot),
    .m_encoding_id    (m_encoding_id),
    .m_option_count   (m_option_count),
    .m_status         (m_status),
    .m_last           (m_last)
);

// ===== tb/tb_tunnel_url_parser_top.sv =====
`timescale 1ns / 100ps

module tb_tunnel_url_parser_top;
    import tup_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES  = 120;   // receiver hold-off under pressure
    localparam int QUIET_LIMIT  = 4000;  // cycles without any transaction
    localparam int DRAIN_CYCLES = 16;    // settle time after the last record
    localparam int MAX_REPORTS  = 10;

    // Parser phases of the prediction
    typedef enum logic [2:0] {
        PH_TRANSPORT,
        PH_SCHEME_SEP,
        PH_SERVER,
        PH_PORT,
        PH_ENC_NAME,
        PH_OPTIONS,
        PH_OVERFLOW
    } parse_phase_t;

    // Receiver pacing schemes
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    logic        aclk       = 1'b0;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [7:0]  s_url_byte = 8'h00;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_byte_value;
    logic [2:0]  m_transport_code;
    logic [15:0] m_port_number;
    logic [3:0]  m_encoding_slot;
    logic        m_encoding_id;
    logic [8:0]  m_option_count;
    logic [3:0]  m_status;
    logic        m_last;

    tunnel_url_parser_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_url_byte       (s_url_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_byte_value     (m_byte_value),
        .m_transport_code (m_transport_code),
        .m_port_number    (m_port_number),
        .m_encoding_slot  (m_encoding_slot),
        .m_encoding_id    (m_encoding_id),
        .m_option_count   (m_option_count),
        .m_status         (m_status),
        .m_last           (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Name tables, indexed by transport code and encoding id
    string transport_names [5] = '{"ip", "ping", "tcp", "udp", "udplite"};
    string encoding_names  [2] = '{"crypt", "pad"};
    string server_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-";
    string option_pool = "abcxyzQ019=,,,,.:;-_/";

    // Predicted records, oldest first
    rec_t pending_records [$];

    // URL under construction before it is sent
    logic [7:0] url_buf [$];

    // Parser state of the prediction
    parse_phase_t ph;
    int unsigned  flen;
    logic [4:0]   tr_hits;
    logic [1:0]   en_hits;
    logic [2:0]   tr_sel;
    logic         enc_sel;
    int unsigned  port_acc;
    int unsigned  enc_idx;
    int unsigned  opt_cnt;
    logic         sep_step;
    logic         drop_rest;

    // Pacing controls, written by the test tasks
    logic        tx_gaps    = 1'b0;
    int unsigned burst_left = 0;
    rx_mode_t    rx_mode    = RX_ALWAYS;
    logic [7:0]  rx_pattern = 8'hFF;
    logic        hold_req   = 1'b0;

    int unsigned err_count  = 0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic is_num(logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_letnum(logic [7:0] b);
        return is_num(b) || ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
    endfunction

    // True when b is the character at pos of the name
    function automatic logic name_has(string nm, int unsigned pos, logic [7:0] b);
        return (pos < nm.len()) && (nm[pos] == b);
    endfunction

    task automatic reset_parser();
        ph        = PH_TRANSPORT;
        flen      = 0;
        tr_hits   = 5'h1F;
        en_hits   = 2'b11;
        tr_sel    = 3'd0;
        enc_sel   = 1'b0;
        port_acc  = 0;
        enc_idx   = 0;
        opt_cnt   = 0;
        sep_step  = 1'b0;
        drop_rest = 1'b0;
    endtask

    task automatic emit_record(logic [1:0] kind, logic [7:0] value, logic [15:0] port,
                               logic [3:0] slot, logic id, logic [8:0] count,
                               logic [3:0] st, logic lst);
        rec_t r;
        r.kind           = kind;
        r.byte_value     = value;
        r.transport_code = tr_sel;
        r.port_number    = port;
        r.encoding_slot  = slot;
        r.encoding_id    = id;
        r.option_count   = count;
        r.status         = st;
        r.last           = lst;
        pending_records.push_back(r);
    endtask

    // Close the URL with a status record; drop the rest unless b is the terminator
    task automatic end_url(logic [3:0] st, logic [7:0] b);
        emit_record(KIND_FIN, 8'h00, (st == ST_OK) ? port_acc[15:0] : 16'd0,
                    4'(enc_idx), 1'b0, 9'(opt_cnt), st, 1'b1);
        reset_parser();
        if (b != 8'h00) drop_rest = 1'b1;
    endtask

    task automatic close_encoding(logic [7:0] b, logic had_opts);
        if (had_opts && opt_cnt < 511) opt_cnt++;
        if (enc_idx < 15) enc_idx++;
        if (b == 8'h00) begin
            end_url(ST_OK, b);
        end else if (b == "+") begin
            if (enc_idx >= ENCODINGS_MAX) begin
                ph = PH_OVERFLOW;
            end else begin
                ph      = PH_ENC_NAME;
                flen    = 0;
                en_hits = 2'b11;
            end
        end else begin
            end_url(ST_NO_PLUS, b);
        end
    endtask

    // Advance the prediction by one accepted URL byte
    task automatic parse_url_byte(logic [7:0] b);
        int i;
        int hit;
        if (drop_rest) begin
            if (b == 8'h00) reset_parser();
            return;
        end
        case (ph)
            PH_TRANSPORT: begin
                if (is_letnum(b) && flen < TRANSPORT_NAME_MAX) begin
                    for (i = 0; i < 5; i++)
                        if (!name_has(transport_names[i], flen, b)) tr_hits[i] = 1'b0;
                    flen++;
                end else if (b == ":") begin
                    ph       = PH_SCHEME_SEP;
                    sep_step = 1'b0;
                end else begin
                    end_url(ST_NO_SCHEME_SEP, b);
                end
            end
            PH_SCHEME_SEP: begin
                if (b != "/") begin
                    end_url(ST_NO_SCHEME_SEP, b);
                end else if (!sep_step) begin
                    sep_step = 1'b1;
                end else begin
                    hit = -1;
                    for (i = 4; i >= 0; i--)
                        if (tr_hits[i] && transport_names[i].len() == flen) hit = i;
                    if (hit < 0) begin
                        end_url(ST_BAD_TRANSPORT, b);
                    end else begin
                        tr_sel = 3'(hit);
                        ph     = PH_SERVER;
                        flen   = 0;
                    end
                end
            end
            PH_SERVER: begin
                if (flen < SERVER_LEN_MAX && (is_letnum(b) || b == "." || b == "-")) begin
                    flen++;
                    emit_record(KIND_SERVER, b, 16'd0, 4'd0, 1'b0, 9'd0, ST_OK, 1'b0);
                end else if (b == ":") begin
                    ph       = PH_PORT;
                    flen     = 0;
                    port_acc = 0;
                end else begin
                    end_url(ST_NO_COLON, b);
                end
            end
            PH_PORT: begin
                if (flen < PORT_DIGITS_MAX && is_num(b)) begin
                    port_acc = port_acc * 10 + (b - 8'h30);
                    if (port_acc > 65536) port_acc = 65536;
                    flen++;
                end else if (flen == 0) begin
                    end_url(ST_NO_PORT, b);
                end else if (port_acc > ((tr_sel == TR_IP) ? 255 : 65535)) begin
                    end_url(ST_PORT_RANGE, b);
                end else if (b == 8'h00) begin
                    end_url(ST_OK, b);
                end else if (b == "?") begin
                    ph      = PH_ENC_NAME;
                    flen    = 0;
                    en_hits = 2'b11;
                end else begin
                    end_url(ST_NO_QUERY, b);
                end
            end
            PH_ENC_NAME: begin
                if (is_letnum(b) && flen < ENCODING_NAME_MAX) begin
                    for (i = 0; i < 2; i++)
                        if (!name_has(encoding_names[i], flen, b)) en_hits[i] = 1'b0;
                    flen++;
                end else if (flen == 0) begin
                    end_url(ST_NO_ENC_NAME, b);
                end else begin
                    hit = -1;
                    for (i = 1; i >= 0; i--)
                        if (en_hits[i] && encoding_names[i].len() == flen) hit = i;
                    if (hit < 0) begin
                        end_url(ST_BAD_ENCODING, b);
                    end else begin
                        enc_sel = (hit == 1);
                        emit_record(KIND_ENC_BEGIN, 8'h00, 16'd0, 4'(enc_idx), enc_sel,
                                    9'(opt_cnt), ST_OK, 1'b0);
                        opt_cnt = 0;
                        if (b == "=") begin
                            ph   = PH_OPTIONS;
                            flen = 0;
                        end else begin
                            close_encoding(b, 1'b0);
                        end
                    end
                end
            end
            PH_OPTIONS: begin
                if (b != 8'h00 && b != "+" && flen < OPTIONS_LEN_MAX) begin
                    flen++;
                    if (b == "," && opt_cnt < 511) opt_cnt++;
                    emit_record(KIND_OPTION, (b == ",") ? 8'h00 : b, 16'd0, 4'(enc_idx),
                                enc_sel, 9'd0, ST_OK, 1'b0);
                end else begin
                    close_encoding(b, 1'b1);
                end
            end
            default: begin
                if (b == 8'h00) end_url(ST_OK, b);
                else end_url(ST_TOO_MANY, b);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one byte, hold it until the transaction, then maybe pause.
    // Valid stays high between bytes of a burst; it only drops for a gap.
    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_url_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_url_byte(b);
        if (tx_gaps) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 5);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic append_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) url_buf.push_back(s[i]);
    endtask

    task automatic send_buffered();
        int i;
        for (i = 0; i < url_buf.size(); i++) send_byte(url_buf[i]);
    endtask

    // Send a whole URL given as text, terminator added
    task automatic send_text(string s);
        url_buf.delete();
        append_text(s);
        url_buf.push_back(8'h00);
        send_buffered();
    endtask

    function automatic logic [7:0] pick_char(string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // Mostly well-formed URL with random content; some corrupted, some noise
    task automatic build_random_url();
        int unsigned n;
        int unsigned k;
        int unsigned e;
        int unsigned port;
        url_buf.delete();
        if ($urandom_range(0, 15) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) url_buf.push_back(8'($urandom_range(0, 255)));
            url_buf.push_back(8'h00);
            return;
        end
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 5);
            repeat (n) url_buf.push_back(pick_char(server_pool));
        end else begin
            append_text(transport_names[$urandom_range(0, 4)]);
        end
        append_text("://");
        n = $urandom_range(1, 6);
        repeat (n) url_buf.push_back(pick_char(server_pool));
        url_buf.push_back(":");
        case ($urandom_range(0, 3))
            0: port = $urandom_range(0, 300);
            1: port = $urandom_range(0, 65535);
            2: port = $urandom_range(65530, 70000);
            default: port = $urandom_range(0, 99);
        endcase
        if ($urandom_range(0, 7) == 0) url_buf.push_back("0");
        append_text($sformatf("%0d", port));
        if ($urandom_range(0, 2) != 0) begin
            url_buf.push_back("?");
            e = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 3);
            for (k = 0; k < e; k++) begin
                if (k != 0) url_buf.push_back("+");
                if ($urandom_range(0, 11) == 0) append_text("pa");
                else append_text(encoding_names[$urandom_range(0, 1)]);
                if ($urandom_range(0, 1) == 1) begin
                    url_buf.push_back("=");
                    n = $urandom_range(0, 6);
                    repeat (n) url_buf.push_back(pick_char(option_pool));
                end
            end
            if ($urandom_range(0, 9) == 0) url_buf.push_back("+");
        end
        url_buf.push_back(8'h00);
        // Corrupt one byte now and then, anywhere before the terminator
        if ($urandom_range(0, 6) == 0)
            url_buf[$urandom_range(0, url_buf.size() - 2)] = 8'($urandom_range(0, 255));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_transport_names();
        tx_gaps = 1'b1;
        rx_mode = RX_COIN;
        send_text("");                        // empty URL: terminator only
        send_text("ip://a:1");
        send_text("ping//x");                 // missing colon of the scheme separator
        send_text("tcp:/x");                  // single slash
        send_text("foo://x:1");               // unknown transport
        send_text("TCP://x:1");               // names are case sensitive
        send_text("udplit://x:1");            // prefix of a longer name
        send_text("udplite://h.x-1:65535");
    endtask

    task automatic test_port_field();
        tx_gaps = 1'b1;
        rx_mode = RX_SPARSE;
        send_text("ip://a:255");              // ip maximum
        send_text("ip://a:256");              // one past the ip maximum
        send_text("tcp://x");                 // no colon before the end
        send_text("tcp://x:");                // empty port
        send_text("tcp://s:65536");
        send_text("udp://s:99999999999999999999");   // saturating accumulator
        // Twenty-one digits: the last digit ends the full field
        url_buf.delete();
        append_text("tcp://s:");
        repeat (21) url_buf.push_back("0");
        url_buf.push_back(8'h00);
        send_buffered();
        send_text("tcp://x:80!");             // junk after the port
    endtask

    task automatic test_encodings();
        tx_gaps = 1'b0;
        rx_mode = RX_COIN;
        send_text("udp://s:7?crypt=k1,,k2+pad");
        send_text("tcp://x:80?");             // no encoding name
        send_text("tcp://x:80?zip");          // unknown encoding
        send_text("tcp://x:80?pad!");         // junk after a name
        send_text("ip://a:0?crypt=");         // empty option list
        // Trailing plus after the last allowed encoding, then end or junk
        send_text("tcp://x:1?pad+pad+pad+pad+pad+pad+pad+pad+");
        send_text("tcp://x:1?pad+crypt+pad+pad+pad+pad+pad+pad+x");
    endtask

    task automatic test_field_limits();
        tx_gaps = 1'b1;
        rx_mode = RX_PATTERN;
        rx_pattern = 8'b1011_0110;
        // Transport name one past its limit
        url_buf.delete();
        repeat (TRANSPORT_NAME_MAX + 1) url_buf.push_back("a");
        append_text("://x:1");
        url_buf.push_back(8'h00);
        send_buffered();
        // Options full of commas, one past the limit: the extra comma ends the list
        url_buf.delete();
        append_text("udp://s:1?crypt=");
        repeat (OPTIONS_LEN_MAX + 1) url_buf.push_back(",");
        url_buf.push_back(8'h00);
        send_buffered();
        // Encoding name one past its limit
        url_buf.delete();
        append_text("tcp://x:1?");
        repeat (ENCODING_NAME_MAX + 1) url_buf.push_back("p");
        url_buf.push_back(8'h00);
        send_buffered();
    endtask

    task automatic test_error_recovery();
        tx_gaps = 1'b1;
        rx_mode = RX_COIN;
        // High byte in the server; the rest is dropped up to the terminator
        url_buf.delete();
        append_text("tcp://");
        url_buf.push_back(8'hC1);
        url_buf.push_back(8'hFF);
        url_buf.push_back(8'h80);
        url_buf.push_back(8'h55);
        url_buf.push_back(8'hAA);
        append_text(":1");
        url_buf.push_back(8'h00);
        send_buffered();
        send_text("ip://z:9?pad=q");          // a clean URL right after recovery
    endtask

    task automatic test_random_traffic(int unsigned budget, logic gaps, rx_mode_t mode);
        int unsigned sent;
        sent       = 0;
        tx_gaps    = gaps;
        rx_mode    = mode;
        rx_pattern = 8'($urandom_range(1, 255));
        while (sent < budget) begin
            build_random_url();
            send_buffered();
            sent += url_buf.size();
        end
    endtask

    // Hold the receiver off while the sender keeps offering server bytes,
    // so the result queue fills and s_ready drops
    task automatic test_backpressure();
        tx_gaps  = 1'b0;
        rx_mode  = RX_ALWAYS;
        hold_req = 1'b1;
        url_buf.delete();
        append_text("tcp://");
        repeat (24) url_buf.push_back(pick_char(server_pool));
        append_text(":80?pad=a,b,c");
        url_buf.push_back(8'h00);
        send_buffered();
        hold_req = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall on the selected scheme, or hold off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        logic [2:0]  rx_phase;
        int unsigned hold_left;
        logic        hold_taken;
        rx_phase   = 3'd0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_req) begin
                hold_taken = 1'b0;
            end else if (!hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  m_ready <= 1'b1;
                    RX_COIN:    m_ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: m_ready <= rx_pattern[rx_phase];
                    default:    m_ready <= ($urandom_range(0, 3) == 0);
                endcase
                rx_phase++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic string describe_rec(rec_t r);
        return $sformatf("kind=%0d byte=%02h tr=%0d port=%0d slot=%0d id=%0d opts=%0d st=%0d last=%0d",
                         r.kind, r.byte_value, r.transport_code, r.port_number,
                         r.encoding_slot, r.encoding_id, r.option_count, r.status, r.last);
    endfunction

    task automatic flag_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Compare every record transaction with the oldest prediction
    always @(posedge aclk) begin : record_check
        rec_t got;
        rec_t want;
        if (aresetn && m_valid && m_ready) begin
            got.kind           = m_kind;
            got.byte_value     = m_byte_value;
            got.transport_code = m_transport_code;
            got.port_number    = m_port_number;
            got.encoding_slot  = m_encoding_slot;
            got.encoding_id    = m_encoding_id;
            got.option_count   = m_option_count;
            got.status         = m_status;
            got.last           = m_last;
            if (pending_records.size() == 0) begin
                flag_error($sformatf("unexpected record %s", describe_rec(got)));
            end else begin
                want = pending_records.pop_front();
                if (got !== want)
                    flag_error($sformatf("expected %s, got %s",
                                         describe_rec(want), describe_rec(got)));
            end
        end
    end

    // End the run when nothing has been accepted on either channel for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_parser();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_transport_names();
        test_port_field();
        test_encodings();
        test_field_limits();
        test_error_recovery();
        test_random_traffic(30, 1'b0, RX_ALWAYS);
        test_random_traffic(30, 1'b1, RX_COIN);
        test_random_traffic(30, 1'b1, RX_PATTERN);
        test_backpressure();
        test_random_traffic(20, 1'b1, RX_SPARSE);

        // Drop valid, open the receiver and drain the remaining records
        @(negedge aclk);
        s_valid <= 1'b0;
        rx_mode = RX_ALWAYS;
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
